// ===== hw/rtl/hcbp_pkg.sv =====
// shared types and constants of the huffman code bit packer
// no dependencies

package hcbp_pkg;

	localparam int BYTE_BITS = 8;
	localparam int WORD_W    = 32;
	localparam int LEN_W     = 6;
	localparam int ACC_W     = 39;
	localparam int TOT_W     = 6;
	localparam int PART_W    = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_ENCODE = 2'd1;
	localparam logic [1:0] FUNC_FLUSH  = 2'd2;

	typedef enum logic {
		OP_ENCODE,
		OP_FLUSH
	} op_kind_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} code_entry_t;

	typedef struct packed {
		op_kind_t    kind;
		code_entry_t code;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  op;
	} push_t;

	typedef struct packed {
		logic full;
		logic valid;
		op_t  head;
	} queue_status_t;

endpackage

// ===== hw/rtl/hcbp_front.sv =====
// front part: accepts items, writes the code table on load, looks up codes on encode
// depends on hcbp_pkg

module hcbp_front #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [7:0]                    symbol,
	input  logic [hcbp_pkg::WORD_W-1:0]   code_word,
	input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
	input  logic                          queue_full,
	output hcbp_pkg::push_t               push_o
);
	import hcbp_pkg::*;

	localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIM = (MAX_CODE_LEN > WORD_W) ? WORD_W : MAX_CODE_LEN;

	code_entry_t mem_q [SYMBOL_COUNT];

	logic        valid_s1;
	op_kind_t    kind_s1;
	code_entry_t rd_s1;

	logic              accept;
	logic              in_range;
	logic [IDX_W-1:0]  idx;
	logic [LEN_W-1:0]  len_sat;
	logic [WORD_W-1:0] word_mask;
	code_entry_t       wr_entry;

	assign in_stall = valid_s1 && queue_full;
	assign accept   = in_valid && !in_stall;
	assign in_range = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign idx      = symbol[IDX_W-1:0];

	always_comb begin
		len_sat = (code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : code_length;
		if (len_sat >= LEN_W'(WORD_W)) begin
			word_mask = '1;
		end else begin
			word_mask = ~({WORD_W{1'b1}} << len_sat);
		end
		wr_entry.word = code_word & word_mask;
		wr_entry.len  = len_sat;
	end

	always_ff @(posedge clk) begin
		if (accept && func == FUNC_LOAD && in_range) begin
			mem_q[idx] <= wr_entry;
		end
		if (accept && func == FUNC_ENCODE) begin
			rd_s1 <= mem_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= OP_ENCODE;
		end else if (accept) begin
			valid_s1 <= (func == FUNC_FLUSH) || (func == FUNC_ENCODE && in_range);
			kind_s1  <= (func == FUNC_FLUSH) ? OP_FLUSH : OP_ENCODE;
		end else if (!queue_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		push_o.push    = valid_s1 && !queue_full;
		push_o.op.kind = kind_s1;
		push_o.op.code = rd_s1;
	end

endmodule

// ===== hw/rtl/hcbp_queue.sv =====
// short queue of classified operations between front and back
// depends on hcbp_pkg

module hcbp_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hcbp_pkg::push_t           push_i,
	input  logic                      pop,
	output hcbp_pkg::queue_status_t   status_o
);
	import hcbp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	logic do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push_i.push) begin
			slot_q[wr_ptr_q] <= push_i.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_i.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push_i.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_comb begin
		status_o.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
		status_o.valid = (count_q != '0);
		status_o.head  = slot_q[rd_ptr_q];
	end

endmodule

// ===== hw/rtl/hcbp_back.sv =====
// back part: bit accumulator, byte splitter and output register
// depends on hcbp_pkg

module hcbp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hcbp_pkg::queue_status_t q_i,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [7:0]              out_byte,
	output logic                    byte_valid,
	output logic [2:0]              pad_bits,
	output logic                    is_final,
	output logic                    last
);
	import hcbp_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [TOT_W-1:0] total_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             byte_valid_q;
	logic [2:0]       pad_bits_q;
	logic             is_final_q;
	logic             last_q;

	logic              out_free;
	logic              busy;
	logic              emit;
	logic              last_emit;
	logic              pop_enc;
	logic              pop_fl;
	logic [2:0]        part_cnt;
	logic [PART_W-1:0] part_bits;
	logic [ACC_W-1:0]  new_acc;
	logic [TOT_W-1:0]  new_total;
	logic [ACC_W-1:0]  shifted;
	logic [7:0]        flush_byte;
	logic [3:0]        pad_full;

	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		busy      = total_q >= TOT_W'(BYTE_BITS);
		emit      = busy && out_free;
		last_emit = emit && (total_q < TOT_W'(2 * BYTE_BITS));
		pop_enc   = q_i.valid && q_i.head.kind == OP_ENCODE && (!busy || last_emit);
		pop_fl    = q_i.valid && q_i.head.kind == OP_FLUSH && !busy && out_free;
		pop       = pop_enc || pop_fl;

		part_cnt  = total_q[2:0];
		part_bits = acc_q[PART_W-1:0] & ~({PART_W{1'b1}} << part_cnt);
		new_acc   = (ACC_W'(part_bits) << q_i.head.code.len) | ACC_W'(q_i.head.code.word);
		new_total = TOT_W'(part_cnt) + q_i.head.code.len;

		shifted    = acc_q >> (total_q - TOT_W'(BYTE_BITS));
		pad_full   = 4'(BYTE_BITS) - 4'(part_cnt);
		flush_byte = 8'(16'(part_bits) << pad_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			total_q <= '0;
		end else if (pop_enc) begin
			acc_q   <= new_acc;
			total_q <= new_total;
		end else if (emit) begin
			total_q <= total_q - TOT_W'(BYTE_BITS);
		end else if (pop_fl) begin
			total_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || pop_fl) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= shifted[7:0];
			byte_valid_q <= 1'b1;
			pad_bits_q   <= '0;
			is_final_q   <= 1'b0;
			last_q       <= total_q < TOT_W'(2 * BYTE_BITS);
		end else if (pop_fl) begin
			out_byte_q   <= flush_byte;
			byte_valid_q <= part_cnt != 3'd0;
			pad_bits_q   <= pad_full[2:0];
			is_final_q   <= 1'b1;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign pad_bits   = pad_bits_q;
	assign is_final   = is_final_q;
	assign last       = last_q;

endmodule

// ===== hw/rtl/huffman_code_bit_packer_top.sv =====
// huffman code bit packer: items pass front, queue, accumulator and output registers
// front takes one item per cycle while in_stall is low; loads end at the front
// back: an encode is taken with the last whole byte pending, or at once if none is;
// a flush is taken after the last byte ahead of it has been emitted
// the output byte register and the bit accumulator set the sustained rate
// reset clears accumulator, queue and handshake state; the code table is not reset
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back

module huffman_code_bit_packer_top #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    func,
	input  logic [7:0]                    symbol,
	input  logic [hcbp_pkg::WORD_W-1:0]   code_word,
	input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          byte_valid,
	output logic [2:0]                    pad_bits,
	output logic                          is_final,
	output logic                          last
);
	import hcbp_pkg::*;

	push_t         push;
	queue_status_t q_status;
	logic          pop;

	hcbp_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.symbol      (symbol),
		.code_word   (code_word),
		.code_length (code_length),
		.queue_full  (q_status.full),
		.push_o      (push)
	);

	hcbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_i   (push),
		.pop      (pop),
		.status_o (q_status)
	);

	hcbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_i        (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.pad_bits   (pad_bits),
		.is_final   (is_final),
		.last       (last)
	);

endmodule
